[src/b64d_pkg.sv]
`timescale 1ns / 1ps

package b64d_pkg;

  // End record status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
  localparam logic [1:0] STATUS_PAD_TEXT  = 2'd2;
  localparam logic [1:0] STATUS_LONE_CHAR = 2'd3;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  // Queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified input item: up to three data bytes and an optional end record
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       eom;
    logic [1:0] status;
  } job_t;

  // Map a character to {valid, sextet}; valid is low outside the alphabet (NUL too)
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
      r = {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

[src/b64d_front.sv]
`timescale 1ns / 1ps

module b64d_front import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [17:0] group_q, group_d;
  logic [1:0]  pend_q, pend_d;
  logic        pad_q, pad_d;
  logic [1:0]  after_q, after_d;
  logic        bad_q, bad_d;
  logic [6:0]  sx;
  logic [23:0] full;
  job_t        job;

  assign sx   = sextet_of(char_i);
  assign full = {group_q, sx[5:0]};

  // Classify the item and work out the next decoder state and its results
  always_comb begin
    group_d    = group_q;
    pend_d     = pend_q;
    pad_d      = pad_q;
    after_d    = after_q;
    bad_d      = bad_q;
    job        = '0;
    job.status = STATUS_OK;

    if (bad_q) begin
      // drop everything until the end of the message
    end else if (pad_q) begin
      if (after_q != 2'd3) begin
        after_d = after_q + 2'd1;
      end
    end else if (char_i == CHAR_PAD) begin
      pad_d = 1'b1;
    end else if (!sx[6]) begin
      bad_d = 1'b1;
    end else if (pend_q == 2'd3) begin
      job.b0     = full[23:16];
      job.b1     = full[15:8];
      job.b2     = full[7:0];
      job.nbytes = 2'd3;
      group_d    = '0;
      pend_d     = 2'd0;
    end else begin
      group_d = full[17:0];
      pend_d  = pend_q + 2'd1;
    end

    // Flush a partial group and close the message
    if (last_i) begin
      job.eom = 1'b1;
      if (bad_d) begin
        job.status = STATUS_BAD_CHAR;
      end else if (after_d == 2'd3) begin
        job.status = STATUS_PAD_TEXT;
      end else if (pend_d == 2'd1) begin
        job.status = STATUS_LONE_CHAR;
      end else if (pend_d == 2'd2) begin
        job.b0     = group_d[11:4];
        job.nbytes = 2'd1;
      end else if (pend_d == 2'd3) begin
        job.b0     = group_d[17:10];
        job.b1     = group_d[9:2];
        job.nbytes = 2'd2;
      end
      group_d = '0;
      pend_d  = 2'd0;
      pad_d   = 1'b0;
      after_d = 2'd0;
      bad_d   = 1'b0;
    end
  end

  assign job_o  = job;
  assign push_o = take_i && (job.nbytes != 2'd0 || job.eom);

  // Hold decoder state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      pend_q  <= 2'd0;
      pad_q   <= 1'b0;
      after_q <= 2'd0;
      bad_q   <= 1'b0;
    end else if (take_i) begin
      group_q <= group_d;
      pend_q  <= pend_d;
      pad_q   <= pad_d;
      after_q <= after_d;
      bad_q   <= bad_d;
    end
  end

endmodule

[src/b64d_queue.sv]
`timescale 1ns / 1ps

module b64d_queue import b64d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  localparam logic [QUEUE_AW:0] Depth = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  job_t                slots_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, wr_d;
  logic [QUEUE_AW-1:0] rd_q, rd_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == Depth);
  assign valid_o = (cnt_q != '0);
  assign job_o   = slots_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= job_i;
    end
  end

endmodule

[src/b64d_back.sv]
`timescale 1ns / 1ps

module b64d_back import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  job_t        q_job_i,
  output logic        q_pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [7:0]  m_byte_o,
  output logic        m_byte_valid_o,
  output logic [1:0]  m_status_o,
  output logic        m_eom_o
);

  job_t       cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       is_end;
  logic       last_res;
  logic       hs;
  logic       load;

  assign hs       = cur_valid_q && m_ready_i;
  assign is_end   = (idx_q == cur_q.nbytes);
  assign last_res = cur_q.eom ? is_end : (idx_q == cur_q.nbytes - 2'd1);
  assign load     = !cur_valid_q || (hs && last_res);
  assign q_pop_o  = load && q_valid_i;

  // Select the result at the current index of the job
  always_comb begin
    m_byte_o = 8'h00;
    case (idx_q)
      2'd0:    m_byte_o = cur_q.b0;
      2'd1:    m_byte_o = cur_q.b1;
      2'd2:    m_byte_o = cur_q.b2;
      default: m_byte_o = 8'h00;
    endcase
    if (is_end) begin
      m_byte_o = 8'h00;
    end
  end

  assign m_valid_o      = cur_valid_q;
  assign m_byte_valid_o = !is_end;
  assign m_status_o     = is_end ? cur_q.status : STATUS_OK;
  assign m_eom_o        = is_end;

  // Load the next job or advance through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      cur_valid_q <= q_valid_i;
      idx_q       <= 2'd0;
    end else if (hs) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_job_i;
    end
  end

endmodule

[src/base64_stream_decoder.sv]
`timescale 1ns / 1ps
// Base64 stream decoder.
// Input stream: one character per item in s_axis_tdata[7:0]; s_axis_tlast marks the
// final character of a message. Output stream: one result per item; tuser high marks
// a data byte in tdata[7:0], tuser low with tlast high is the end record whose
// status sits in tdata[9:8] (ok, bad character, text after padding, lone final char).
// Throughput: one character per cycle sustained with m_axis_tready high. Each character that yields results
// becomes a job of up to four results in a four-entry queue; the output side drains
// one result a cycle, so a full group (four characters, three bytes) keeps pace.
// Each accepted character's job is written to the queue and then loaded into the
// output job register, from which its first result is presented on the output.
// Reset clears decoder state, queue and output; no clearing pass is needed.
// When the receiver stalls the current result holds; the queue keeps taking input
// until it holds four jobs, then s_axis_tready drops until a job is drained.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
  output logic        m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast    // end_of_message
);

  logic       take;
  logic       push;
  job_t       push_job;
  logic       q_full;
  logic       q_valid;
  job_t       q_job;
  logic       q_pop;
  logic [7:0] out_byte;
  logic [1:0] out_status;

  assign s_axis_tready = !q_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  b64d_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .char_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .push_o (push),
    .job_o  (push_job)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job),
    .pop_i   (q_pop)
  );

  b64d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_job_i        (q_job),
    .q_pop_o        (q_pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_byte_o       (out_byte),
    .m_byte_valid_o (m_axis_tuser),
    .m_status_o     (out_status),
    .m_eom_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_status, out_byte};

`ifndef NO_ASSERTIONS
  // Every pushed job carries at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_job.nbytes != 2'd0 || push_job.eom))
    else $error("empty job pushed");

  // The end record is never flagged as a data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
    else $error("end record marked as data");

  // Data bytes carry an ok status and the padding bits stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[15:8] == 8'h00))
    else $error("data byte with status");

  // An accepted last character always leads to a pushed end record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && s_axis_tlast |-> push && push_job.eom)
    else $error("end record lost");
`endif

endmodule
